FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; expects a clock named clock and a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lpi_pkg.sv
// Shared types and constants of the line pair intersection block.
// Depends on nothing; used by every module of the block.
package lpi_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int OUT_WIDTH   = 32;

   // signed coordinate difference
   localparam int DW = COORD_WIDTH + 1;
   // signed determinant / numerator, and its magnitude
   localparam int PW = 2 * DW + 1;
   localparam int MW = PW - 1;
   // magnitude of numerator times direction
   localparam int PM = MW + COORD_WIDTH;
   // quotient bits kept before the result is known to saturate
   localparam int QW = ((COORD_WIDTH - 1 + FRAC_BITS) > OUT_WIDTH ?
                        (COORD_WIDTH - 1 + FRAC_BITS) : OUT_WIDTH) + 1;
   // dividend width
   localparam int NW = ((PM + FRAC_BITS + 2) > (QW + MW + 1)) ?
                       (PM + FRAC_BITS + 2) : (QW + MW + 1);
   localparam int TW = NW - QW;
   // signed point value before saturation
   localparam int VW = QW + 2;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   typedef enum logic [1:0] {
      REL_CROSS      = 2'd0,
      REL_PARALLEL   = 2'd1,
      REL_COINCIDENT = 2'd2,
      REL_DEGENERATE = 2'd3
   } relation_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_start_x;
      logic signed [COORD_WIDTH-1:0] first_start_y;
      logic signed [COORD_WIDTH-1:0] first_end_x;
      logic signed [COORD_WIDTH-1:0] first_end_y;
      logic signed [COORD_WIDTH-1:0] second_start_x;
      logic signed [COORD_WIDTH-1:0] second_start_y;
      logic signed [COORD_WIDTH-1:0] second_end_x;
      logic signed [COORD_WIDTH-1:0] second_end_y;
   } req_type;

   typedef struct packed {
      relation_type                relation;
      logic signed [OUT_WIDTH-1:0] cross_x;
      logic signed [OUT_WIDTH-1:0] cross_y;
      logic                        clipped;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      relation_type                  relation;
      logic signed [COORD_WIDTH-1:0] base_x;
      logic signed [COORD_WIDTH-1:0] base_y;
      logic                          neg_x;
      logic                          neg_y;
      logic [MW-1:0]                 num_mag;
      logic [MW-1:0]                 det_mag;
      logic [COORD_WIDTH-1:0]        dir_x_mag;
      logic [COORD_WIDTH-1:0]        dir_y_mag;
   } mid_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

FILE: hw/rtl/lpi_front.sv
// Front end: differences, cross products and classification of a line pair.
// Depends on lpi_pkg; feeds lpi_queue.
module lpi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  lpi_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output lpi_pkg::mid_type q_data
);

   localparam int CW = lpi_pkg::COORD_WIDTH;
   localparam int DW = lpi_pkg::DW;
   localparam int PW = lpi_pkg::PW;
   localparam int MW = lpi_pkg::MW;

   function automatic logic signed [DW-1:0] diff(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
      return DW'(a) - DW'(b);
   endfunction

   function automatic logic [MW-1:0] mag_p(logic signed [PW-1:0] v);
      logic signed [PW-1:0] m;
      m = v[PW-1] ? -v : v;
      return m[MW-1:0];
   endfunction

   function automatic logic [CW-1:0] mag_d(logic signed [DW-1:0] v);
      logic signed [DW-1:0] m;
      m = v[DW-1] ? -v : v;
      return m[CW-1:0];
   endfunction

   logic en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // stage 1
   logic signed [DW-1:0] s1_dx1_ff, s1_dy1_ff, s1_dx2_ff, s1_dy2_ff, s1_qx_ff, s1_qy_ff;
   logic signed [CW-1:0] s1_x1_ff, s1_y1_ff;
   logic                 s1_degen_ff;
   // stage 2
   logic signed [2*DW-1:0] s2_da_ff, s2_db_ff, s2_ca_ff, s2_cb_ff, s2_na_ff, s2_nb_ff;
   logic signed [DW-1:0]   s2_dx1_ff, s2_dy1_ff;
   logic signed [CW-1:0]   s2_x1_ff, s2_y1_ff;
   logic                   s2_degen_ff;
   // stage 3
   lpi_pkg::mid_type s3_in, s3_ff;
   logic signed [PW-1:0] det, col, num;

   assign en     = !s3_valid_ff || !q_full;
   assign full   = !en;
   assign q_push = s3_valid_ff && en;
   assign q_data = s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= push;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx1_ff   <= diff(req_data.first_end_x, req_data.first_start_x);
         s1_dy1_ff   <= diff(req_data.first_end_y, req_data.first_start_y);
         s1_dx2_ff   <= diff(req_data.second_end_x, req_data.second_start_x);
         s1_dy2_ff   <= diff(req_data.second_end_y, req_data.second_start_y);
         s1_qx_ff    <= diff(req_data.second_start_x, req_data.first_start_x);
         s1_qy_ff    <= diff(req_data.second_start_y, req_data.first_start_y);
         s1_x1_ff    <= req_data.first_start_x;
         s1_y1_ff    <= req_data.first_start_y;
         s1_degen_ff <= (req_data.first_start_x == req_data.first_end_x &&
                         req_data.first_start_y == req_data.first_end_y) ||
                        (req_data.second_start_x == req_data.second_end_x &&
                         req_data.second_start_y == req_data.second_end_y);

         s2_da_ff    <= s1_dx1_ff * s1_dy2_ff;
         s2_db_ff    <= s1_dy1_ff * s1_dx2_ff;
         s2_ca_ff    <= s1_dx1_ff * s1_qy_ff;
         s2_cb_ff    <= s1_dy1_ff * s1_qx_ff;
         s2_na_ff    <= s1_qx_ff * s1_dy2_ff;
         s2_nb_ff    <= s1_qy_ff * s1_dx2_ff;
         s2_dx1_ff   <= s1_dx1_ff;
         s2_dy1_ff   <= s1_dy1_ff;
         s2_x1_ff    <= s1_x1_ff;
         s2_y1_ff    <= s1_y1_ff;
         s2_degen_ff <= s1_degen_ff;

         s3_ff <= s3_in;
      end
   end

   always_comb begin
      det = PW'(s2_da_ff) - PW'(s2_db_ff);
      col = PW'(s2_ca_ff) - PW'(s2_cb_ff);
      num = PW'(s2_na_ff) - PW'(s2_nb_ff);

      s3_in.base_x    = s2_x1_ff;
      s3_in.base_y    = s2_y1_ff;
      s3_in.neg_x     = num[PW-1] ^ s2_dx1_ff[DW-1] ^ det[PW-1];
      s3_in.neg_y     = num[PW-1] ^ s2_dy1_ff[DW-1] ^ det[PW-1];
      s3_in.num_mag   = mag_p(num);
      s3_in.det_mag   = mag_p(det);
      s3_in.dir_x_mag = mag_d(s2_dx1_ff);
      s3_in.dir_y_mag = mag_d(s2_dy1_ff);

      if (s2_degen_ff) begin
         s3_in.relation = lpi_pkg::REL_DEGENERATE;
      end else if (det == '0) begin
         s3_in.relation = (col == '0) ? lpi_pkg::REL_COINCIDENT : lpi_pkg::REL_PARALLEL;
      end else begin
         s3_in.relation = lpi_pkg::REL_CROSS;
      end
   end

endmodule

FILE: hw/rtl/lpi_queue.sv
// Short queue of classified items between front and back.
// Depends on lpi_pkg.
module lpi_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lpi_pkg::mid_type       push_data,
   input  logic                   pop,
   output lpi_pkg::mid_type       pop_data,
   output lpi_pkg::fifo_stat_type stat
);

   localparam int AW = lpi_pkg::QAW;

   lpi_pkg::mid_type mem_ff [lpi_pkg::QDEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;

   assign stat.full  = (count_ff == (AW+1)'(lpi_pkg::QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/lpi_back.sv
// Back end: pipelined division into fixed point, rounding and saturation.
// Depends on lpi_pkg; drains lpi_queue and holds the result register.
module lpi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lpi_pkg::mid_type       q_data,
   input  lpi_pkg::fifo_stat_type q_stat,
   output logic                   q_pop,
   input  logic                   pop,
   output logic                   empty,
   output lpi_pkg::rsp_type       rsp_data
);

   localparam int CW = lpi_pkg::COORD_WIDTH;
   localparam int FB = lpi_pkg::FRAC_BITS;
   localparam int OW = lpi_pkg::OUT_WIDTH;
   localparam int MW = lpi_pkg::MW;
   localparam int PM = lpi_pkg::PM;
   localparam int NW = lpi_pkg::NW;
   localparam int QW = lpi_pkg::QW;
   localparam int TW = lpi_pkg::TW;
   localparam int VW = lpi_pkg::VW;

   localparam logic signed [VW-1:0] SAT_HI = {{(VW-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic signed [VW-1:0] SAT_LO = {{(VW-OW+1){1'b1}}, {(OW-1){1'b0}}};

   typedef struct packed {
      lpi_pkg::relation_type relation;
      logic signed [CW-1:0]  base_x;
      logic signed [CW-1:0]  base_y;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ov_x;
      logic                  ov_y;
      logic [MW:0]           dv;
      logic [MW:0]           rem_x;
      logic [MW:0]           rem_y;
      logic [QW-1:0]         low_x;
      logic [QW-1:0]         low_y;
      logic [QW-1:0]         quo_x;
      logic [QW-1:0]         quo_y;
   } div_type;

   // one restoring step: bring in the next dividend bit
   function automatic logic [MW+QW:0] step(logic [MW:0] rem, logic [QW-1:0] low,
                                           logic [QW-1:0] quo, logic [MW:0] dv);
      logic [MW+1:0] t;
      logic          b;
      t = {rem, low[QW-1]};
      b = (t >= {1'b0, dv});
      if (b) begin
         t = t - {1'b0, dv};
      end
      return {t[MW:0], quo[QW-2:0], b};
   endfunction

   function automatic div_type div_step(div_type s);
      div_type       r;
      logic [MW+QW:0] sx, sy;
      r = s;
      sx = step(s.rem_x, s.low_x, s.quo_x, s.dv);
      sy = step(s.rem_y, s.low_y, s.quo_y, s.dv);
      r.rem_x = sx[MW+QW:QW];
      r.quo_x = sx[QW-1:0];
      r.rem_y = sy[MW+QW:QW];
      r.quo_y = sy[QW-1:0];
      r.low_x = {s.low_x[QW-2:0], 1'b0};
      r.low_y = {s.low_y[QW-2:0], 1'b0};
      return r;
   endfunction

   // returns {clip, value}
   function automatic logic [OW:0] fix(logic signed [CW-1:0] base, logic neg, logic ov,
                                       logic [QW-1:0] quo);
      logic signed [VW-1:0] val;
      val = VW'(base) <<< FB;
      if (neg) begin
         val = val - $signed({2'b00, quo});
      end else begin
         val = val + $signed({2'b00, quo});
      end
      if (ov) begin
         return neg ? {1'b1, SAT_LO[OW-1:0]} : {1'b1, SAT_HI[OW-1:0]};
      end else if (val > SAT_HI) begin
         return {1'b1, SAT_HI[OW-1:0]};
      end else if (val < SAT_LO) begin
         return {1'b1, SAT_LO[OW-1:0]};
      end
      return {1'b0, val[OW-1:0]};
   endfunction

   logic en;

   logic             m_valid_ff;
   lpi_pkg::mid_type m_mid_ff;
   logic [PM-1:0]    m_prod_x_ff, m_prod_y_ff;

   logic    valid_ff [QW+1];
   div_type stage_ff [QW+1];
   div_type stage_in [QW+1];

   logic             out_valid_ff;
   lpi_pkg::rsp_type rsp_ff, rsp_in;

   logic [NW-1:0] nx, ny;
   logic [OW:0]   fx, fy;

   assign en       = !out_valid_ff || pop;
   assign q_pop    = en && !q_stat.empty;
   assign empty    = !out_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      nx = NW'({m_prod_x_ff, {(FB+1){1'b0}}}) + NW'(m_mid_ff.det_mag);
      ny = NW'({m_prod_y_ff, {(FB+1){1'b0}}}) + NW'(m_mid_ff.det_mag);

      stage_in[0].relation = m_mid_ff.relation;
      stage_in[0].base_x   = m_mid_ff.base_x;
      stage_in[0].base_y   = m_mid_ff.base_y;
      stage_in[0].neg_x    = m_mid_ff.neg_x;
      stage_in[0].neg_y    = m_mid_ff.neg_y;
      stage_in[0].dv       = {m_mid_ff.det_mag, 1'b0};
      // quotient too wide for QW bits: saturates for sure
      stage_in[0].ov_x     = nx[NW-1:QW] >= TW'({m_mid_ff.det_mag, 1'b0});
      stage_in[0].ov_y     = ny[NW-1:QW] >= TW'({m_mid_ff.det_mag, 1'b0});
      stage_in[0].rem_x    = nx[QW+MW:QW];
      stage_in[0].rem_y    = ny[QW+MW:QW];
      stage_in[0].low_x    = nx[QW-1:0];
      stage_in[0].low_y    = ny[QW-1:0];
      stage_in[0].quo_x    = '0;
      stage_in[0].quo_y    = '0;
      for (int k = 1; k <= QW; k++) begin
         stage_in[k] = div_step(stage_ff[k-1]);
      end
   end

   always_comb begin
      fx = fix(stage_ff[QW].base_x, stage_ff[QW].neg_x, stage_ff[QW].ov_x,
               stage_ff[QW].quo_x);
      fy = fix(stage_ff[QW].base_y, stage_ff[QW].neg_y, stage_ff[QW].ov_y,
               stage_ff[QW].quo_y);
      rsp_in.relation = stage_ff[QW].relation;
      if (stage_ff[QW].relation == lpi_pkg::REL_CROSS) begin
         rsp_in.cross_x = fx[OW-1:0];
         rsp_in.cross_y = fy[OW-1:0];
         rsp_in.clipped = fx[OW] | fy[OW];
      end else begin
         rsp_in.cross_x = '0;
         rsp_in.cross_y = '0;
         rsp_in.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= QW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         m_valid_ff  <= q_pop;
         valid_ff[0] <= m_valid_ff;
         for (int k = 1; k <= QW; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_mid_ff    <= q_data;
         m_prod_x_ff <= PM'(q_data.num_mag) * PM'(q_data.dir_x_mag);
         m_prod_y_ff <= PM'(q_data.num_mag) * PM'(q_data.dir_y_mag);
         for (int k = 0; k <= QW; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: hw/rtl/line_pair_intersection_top.sv
// Line pair intersection: relation of two lines and their crossing point.
//
// Input channel: push, full, req_data (two lines, two endpoints each).
// An item enters at a clock edge with push high and full low.
// Result channel: empty, pop, rsp_data (relation, cross_x, cross_y in
// signed Q16.16, clipped). The oldest result is shown while empty is low
// and leaves at an edge with pop high and empty low.
// One item per cycle sustained while results are popped as they appear.
// From accept to empty low an item passes three front stages, the queue,
// a multiply and a prepare stage, the divider stages with one quotient
// bit per stage (QW = 33 bits with 16-bit coordinates), and the result register.
// A 4-entry queue splits the classifying front from the divider pipeline,
// so a stalled receiver first freezes the back while the front keeps
// filling the queue; full rises once the queue is full and the last front stage holds an item.
// Reset (synchronous, active high) empties every stage and the queue.
// Items are independent; nothing carries from one item to the next.
`include "assert_macros.svh"

module line_pair_intersection_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  lpi_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output lpi_pkg::rsp_type rsp_data
);

   logic                   q_push, q_pop;
   lpi_pkg::mid_type       q_in, q_out;
   lpi_pkg::fifo_stat_type q_stat;

   lpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_stat.full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   lpi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   lpi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_out),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   `ASSERT_IMPLY(a_no_point, !empty && rsp_data.relation != lpi_pkg::REL_CROSS, rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && !rsp_data.clipped, "point given for non-crossing pair")
   `ASSERT_IMPLY(a_q_overrun, q_push, !q_stat.full || q_pop, "queue written while full")
   `ASSERT_IMPLY(a_q_underrun, q_pop, !q_stat.empty, "queue read while empty")
   `ASSERT_IMPLY(a_full_cause, full, q_stat.full, "front stalled with room in queue")

endmodule
